FILE: hdl/ldq_pkg.sv
// ----------------------------------------------------------------------------
// ldq_pkg
// Shared types, constants and the per-channel dither function for the
// temporal dither quantizer.
// ----------------------------------------------------------------------------
package ldq_pkg;

    localparam int POS_W       = 9;
    localparam int ENTRY_W     = POS_W + 1;
    localparam int ENTRY_COUNT = 2 ** ENTRY_W;
    localparam int CHAN_W      = 8;
    localparam int ACC_W       = 8;
    localparam int PROD_W      = 2 * CHAN_W;
    localparam int WORD_W      = 3 * ACC_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [7:0] BRIGHTNESS_RESET = 8'd255;
    localparam logic       DITHER_EN_RESET  = 1'b1;
    localparam logic [7:0] THRESHOLD_RESET  = 8'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS = 2'd0,
        CFG_DITHER_EN  = 2'd1,
        CFG_DITHER_THR = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic       dither_enable;
        logic [7:0] threshold;
    } cfg_t;

    typedef struct packed {
        logic               en;
        logic [ENTRY_W-1:0] addr;
        logic [WORD_W-1:0]  data;
    } acc_wr_t;

    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [CHAN_W-1:0] q;
    } chan_res_t;

    // add a fraction >= thr, carry one unit into the channel, saturate at full scale
    function automatic chan_res_t dither_chan(
        input logic [PROD_W-1:0] prod,
        input logic [ACC_W-1:0]  acc_in,
        input logic [7:0]        thr
    );
        logic [CHAN_W-1:0] frac;
        logic [ACC_W:0]    sum;
        chan_res_t         res;
        frac = prod[CHAN_W-1:0];
        sum  = {1'b0, acc_in};
        if (frac >= thr)
        begin
            sum = sum + {1'b0, frac};
        end
        res.q = prod[PROD_W-1:CHAN_W];
        if (sum[ACC_W] && (res.q != {CHAN_W{1'b1}}))
        begin
            res.q = res.q + 1'b1;
        end
        res.acc = sum[ACC_W-1:0];
        return res;
    endfunction

endpackage

FILE: hdl/ldq_cfg_regs.sv
// ----------------------------------------------------------------------------
// ldq_cfg_regs
// Configuration register file: brightness, dither enable, dither threshold.
// ----------------------------------------------------------------------------
module ldq_cfg_regs
    import ldq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BRIGHTNESS: cfg_next.brightness    = cfg_data[7:0];
                CFG_DITHER_EN:  cfg_next.dither_enable = cfg_data[0];
                CFG_DITHER_THR: cfg_next.threshold     = cfg_data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness    <= BRIGHTNESS_RESET;
            cfg_reg.dither_enable <= DITHER_EN_RESET;
            cfg_reg.threshold     <= THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/ldq_acc_ram.sv
// ----------------------------------------------------------------------------
// ldq_acc_ram
// Fraction accumulator store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ldq_acc_ram
    import ldq_pkg::*;
(
    input  logic               clk,
    input  acc_wr_t            wr,
    input  logic               rd_en,
    input  logic [ENTRY_W-1:0] rd_addr,
    output logic [WORD_W-1:0]  rd_data
);

    logic [WORD_W-1:0] mem [ENTRY_COUNT];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/ldq_pipe.sv
// ----------------------------------------------------------------------------
// ldq_pipe
// Scale, dither and write-back stage plus the output register.
// ----------------------------------------------------------------------------
module ldq_pipe
    import ldq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_accept,
    input  logic [ENTRY_W-1:0] in_addr,
    input  logic [CHAN_W-1:0]  in_red,
    input  logic [CHAN_W-1:0]  in_green,
    input  logic [CHAN_W-1:0]  in_blue,
    input  logic               in_last,
    input  logic [WORD_W-1:0]  rd_data,
    output logic               ready,
    output acc_wr_t            acc_wr,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,
    output logic               m_tlast
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [ENTRY_W-1:0] s1_addr_reg;
    logic [PROD_W-1:0]  prod_r_reg;
    logic [PROD_W-1:0]  prod_g_reg;
    logic [PROD_W-1:0]  prod_b_reg;
    logic               s1_last_reg;

    logic               fwd_valid_reg;
    logic [ENTRY_W-1:0] fwd_addr_reg;
    logic [WORD_W-1:0]  fwd_data_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [23:0]        out_data_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               s1_move;
    logic [WORD_W-1:0]  acc_word;
    chan_res_t          res_r;
    chan_res_t          res_g;
    chan_res_t          res_b;
    logic [CHAN_W-1:0]  q_r;
    logic [CHAN_W-1:0]  q_g;
    logic [CHAN_W-1:0]  q_b;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign ready    = !s1_valid_reg || out_free;

    // take the latest write-back when the read raced it
    assign acc_word = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data;

    assign res_r = dither_chan(prod_r_reg, acc_word[ACC_W-1:0], cfg.threshold);
    assign res_g = dither_chan(prod_g_reg, acc_word[2*ACC_W-1:ACC_W], cfg.threshold);
    assign res_b = dither_chan(prod_b_reg, acc_word[3*ACC_W-1:2*ACC_W], cfg.threshold);

    always_comb
    begin
        if (cfg.dither_enable)
        begin
            q_r = res_r.q;
            q_g = res_g.q;
            q_b = res_b.q;
        end
        else
        begin
            q_r = prod_r_reg[PROD_W-1:CHAN_W];
            q_g = prod_g_reg[PROD_W-1:CHAN_W];
            q_b = prod_b_reg[PROD_W-1:CHAN_W];
        end
    end

    assign acc_wr.en   = s1_move && cfg.dither_enable;
    assign acc_wr.addr = s1_addr_reg;
    assign acc_wr.data = {res_b.acc, res_g.acc, res_r.acc};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (acc_wr.en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg <= in_addr;
            prod_r_reg  <= in_red * cfg.brightness;
            prod_g_reg  <= in_green * cfg.brightness;
            prod_b_reg  <= in_blue * cfg.brightness;
            s1_last_reg <= in_last;
        end
        if (acc_wr.en)
        begin
            fwd_addr_reg <= acc_wr.addr;
            fwd_data_reg <= acc_wr.data;
        end
        if (s1_move)
        begin
            out_data_reg <= {q_b, q_r, q_g};
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hdl/led_temporal_dither_quantizer_top.sv
// ----------------------------------------------------------------------------
// led_temporal_dither_quantizer_top
// Brightness scaler with per-pixel temporal dithering for two LED strips.
//
//   channel   dir  width  contents (lowest bit first)
//   s_*       in   40     tdata: pixel_position, red_in, green_in, blue_in
//                         tuser: strip_select   tlast: last_of_strip
//   m_*       out  24     tdata: first_byte_green, second_byte_red,
//                         third_byte_blue        tlast: frame_end
//   cfg_*     in   8      0 brightness, 1 dither_enable, 2 dither_threshold
//
// One request per clock while the output is not stalled and no clearing pass runs;
// a result passes the scale stage register and then the output register. The accumulator
// RAM is read on acceptance and, with dither enabled, written back as the result leaves the scale
// stage; a back-to-back hit on the same pixel is forwarded from the last write. After reset a
// clearing pass zeroes all 1024 RAM entries; s_tready is low meanwhile. m_tready low holds the
// output register and then the scale stage.
module led_temporal_dither_quantizer_top
    import ldq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // pixel_position, red_in, green_in, blue_in
    input  logic                  s_tuser,   // strip_select
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // first_byte_green, second_byte_red, third_byte_blue
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg;
    logic               pipe_ready;
    logic               in_accept;
    logic [ENTRY_W-1:0] in_addr;
    acc_wr_t            pipe_wr;
    acc_wr_t            ram_wr;
    logic [WORD_W-1:0]  rd_data;

    logic               clearing_reg;
    logic [ENTRY_W-1:0] clr_addr_reg;

    assign s_tready  = !clearing_reg && pipe_ready;
    assign in_accept = s_tvalid && s_tready;
    assign in_addr   = {s_tuser, s_tdata[POS_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ENTRY_W'(ENTRY_COUNT - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_addr_reg;
            ram_wr.data = '0;
        end
        else
        begin
            ram_wr = pipe_wr;
        end
    end

    ldq_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ldq_acc_ram u_acc_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (in_accept),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    ldq_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_addr   (in_addr),
        .in_red    (s_tdata[16:9]),
        .in_green  (s_tdata[24:17]),
        .in_blue   (s_tdata[32:25]),
        .in_last   (s_tlast),
        .rd_data   (rd_data),
        .ready     (pipe_ready),
        .acc_wr    (pipe_wr),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
